### design/tlfq_pkg.sv
// Package: constants and result codes for the three-level feedback queue scheduler.
`default_nettype none
package tlfq_pkg;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 16;
  localparam int unsigned NumLevels     = 3;
  localparam int unsigned CfgBits       = 8;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ACT_QUEUED    = 3'd0,
    ACT_STARTED   = 3'd1,
    ACT_PREEMPTED = 3'd2,
    ACT_IDLE      = 3'd3,
    ACT_REMOVED   = 3'd4,
    ACT_NOT_FOUND = 3'd5,
    ACT_FULL      = 3'd6
  } action_e;

  localparam logic CFG_RUN_QUANTUM = 1'b0;
  localparam logic CFG_IDLE_POLL   = 1'b1;
endpackage
`default_nettype wire

### design/tlfq_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tlfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

### design/three_level_feedback_queue_scheduler.sv
// Top level: three-level feedback queue scheduler with a shared queue RAM.
// A command is taken when start is high and busy low; its single result appears
// on the result ports for one cycle with valid_o and cannot be held off. All queue
// entries live in one RAM (one write, one registered read per cycle). Enqueue
// writes in the execute state; expiry reads the head entry there and answers from
// the head state, or from the execute state when every queue is empty; removal reads
// every queued entry in turn and keeps the rest. Op 3 gives no result.
`default_nettype none
module three_level_feedback_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = tlfq_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS     = tlfq_pkg::IdBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [tlfq_pkg::CfgBits-1:0] cfg_data_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] job_id_i,
  input  wire logic [1:0]  priority_req_i,
  output logic             valid_o,
  output logic [2:0]       action_o,
  output logic [15:0]      job_out_o,
  output logic [1:0]       level_out_o,
  output logic [1:0]       mark_out_o,
  output logic [7:0]       reload_o
);
  import tlfq_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RamDepth = NumLevels * QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(RamDepth);
  localparam int unsigned EW = ID_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_HEAD, S_RM_RD, S_RM_CHK
  } state_e;

  state_e          state_q;
  op_e             op_q;
  logic [ID_BITS-1:0] id_q;
  logic [1:0]      pr_q;
  logic [1:0]      lv_q;
  logic [CW-1:0]   idx_q, k_q;
  logic            found_q;
  logic [1:0]      flv_q, fmark_q;
  logic            run_q;
  logic [1:0]      rl_q;
  logic [PW-1:0]   heads_q [NumLevels];
  logic [CW-1:0]   counts_q [NumLevels];
  logic [7:0]      rq_q, ip_q;

  logic            re, we;
  logic [AW-1:0]   raddr, waddr;
  logic [EW-1:0]   wdata, rdata;

  // (head + offset) mod depth, sum stays below twice the depth
  function automatic logic [PW-1:0] ring(input logic [PW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(o);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return PW'(s);
  endfunction

  function automatic logic [AW-1:0] addr(input logic [1:0] l, input logic [PW-1:0] p);
    return AW'(l) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  tlfq_ram #(.Width(EW), .Depth(RamDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  // decoded command and head-entry fields
  logic [1:0]         enq_lv;
  logic               eff_run, any_ne;
  logic [1:0]         first_lv;
  logic [ID_BITS-1:0] e_id;
  logic [1:0]         e_mark, nm, dst;
  logic               dst_full;

  assign enq_lv = (pr_q == 2'd0) ? 2'd0 : pr_q - 2'd1;
  assign eff_run = run_q && (counts_q[rl_q] != '0);
  assign any_ne = (counts_q[0] != '0) || (counts_q[1] != '0) || (counts_q[2] != '0);
  assign first_lv = (counts_q[0] != '0) ? 2'd0 : (counts_q[1] != '0) ? 2'd1 : 2'd2;
  assign e_id = rdata[EW-1:2];
  assign e_mark = rdata[1:0];

  // mark rules on expiry
  always_comb begin
    nm = 2'd0;
    dst = lv_q;
    case (e_mark)
      2'd0: nm = 2'd1;
      2'd1: begin
        if (lv_q == 2'd2) begin nm = 2'd2; dst = 2'd1; end
        else begin nm = 2'd0; dst = lv_q + 2'd1; end
      end
      2'd2: nm = 2'd3;
      default: begin
        if (lv_q == 2'd0) begin nm = 2'd0; dst = 2'd1; end
        else begin nm = 2'd2; dst = lv_q - 2'd1; end
      end
    endcase
  end
  assign dst_full = (dst != lv_q) && (counts_q[dst] == CW'(QUEUE_DEPTH));

  // RAM port control
  always_comb begin
    re = 1'b0;
    we = 1'b0;
    raddr = '0;
    waddr = '0;
    wdata = '0;
    case (state_q)
      S_EXEC: begin
        if (op_q == OP_ENQ) begin
          we = counts_q[enq_lv] != CW'(QUEUE_DEPTH);
          waddr = addr(enq_lv, ring(heads_q[enq_lv], counts_q[enq_lv]));
          wdata = {id_q, 2'd0};
        end else if (op_q == OP_EXPIRE) begin
          re = 1'b1;
          raddr = eff_run ? addr(rl_q, heads_q[rl_q]) : addr(first_lv, heads_q[first_lv]);
        end
      end
      S_HEAD: begin
        we = run_q && !dst_full;
        waddr = addr(dst, ring(heads_q[dst], counts_q[dst]));
        wdata = {e_id, nm};
      end
      S_RM_RD: begin
        re = idx_q != counts_q[lv_q];
        raddr = addr(lv_q, ring(heads_q[lv_q], idx_q));
      end
      S_RM_CHK: begin
        we = e_id != id_q;
        waddr = addr(lv_q, ring(heads_q[lv_q], k_q));
        wdata = rdata;
      end
      default: ;
    endcase
  end

  assign busy = state_q != S_IDLE;

  // sequencer, queue state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= OP_NONE;
      run_q <= 1'b0;
      rl_q <= 2'd0;
      rq_q <= 8'd5;
      ip_q <= 8'd1;
      valid_o <= 1'b0;
      for (int l = 0; l < NumLevels; l++) begin
        heads_q[l] <= '0;
        counts_q[l] <= '0;
      end
    end else begin
      valid_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RUN_QUANTUM) rq_q <= cfg_data_i;
        else ip_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q <= op_e'(op_i);
            id_q <= ID_BITS'(job_id_i);
            pr_q <= priority_req_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          reload_o <= 8'd0;
          mark_out_o <= 2'd0;
          job_out_o <= 16'(id_q);
          case (op_q)
            OP_ENQ: begin
              valid_o <= 1'b1;
              level_out_o <= enq_lv;
              if (counts_q[enq_lv] == CW'(QUEUE_DEPTH)) begin
                action_o <= ACT_FULL;
              end else begin
                action_o <= ACT_QUEUED;
                counts_q[enq_lv] <= counts_q[enq_lv] + CW'(1);
              end
            end
            OP_EXPIRE: begin
              if (eff_run) begin
                lv_q <= rl_q;
                state_q <= S_HEAD;
              end else begin
                run_q <= 1'b0;
                rl_q <= 2'd0;
                if (any_ne) begin
                  lv_q <= first_lv;
                  state_q <= S_HEAD;
                end else begin
                  valid_o <= 1'b1;
                  action_o <= ACT_IDLE;
                  job_out_o <= 16'd0;
                  level_out_o <= 2'd0;
                  reload_o <= ip_q;
                end
              end
            end
            OP_REMOVE: begin
              lv_q <= 2'd0;
              idx_q <= '0;
              k_q <= '0;
              found_q <= 1'b0;
              flv_q <= 2'd0;
              fmark_q <= 2'd0;
              state_q <= S_RM_RD;
            end
            default: ;
          endcase
        end
        S_HEAD: begin
          state_q <= S_IDLE;
          valid_o <= 1'b1;
          job_out_o <= 16'(e_id);
          if (run_q) begin
            run_q <= 1'b0;
            rl_q <= 2'd0;
            level_out_o <= dst;
            mark_out_o <= nm;
            reload_o <= 8'd0;
            if (dst_full) begin
              action_o <= ACT_FULL;
            end else begin
              action_o <= ACT_PREEMPTED;
              heads_q[lv_q] <= ring(heads_q[lv_q], CW'(1));
              if (dst != lv_q) begin
                counts_q[lv_q] <= counts_q[lv_q] - CW'(1);
                counts_q[dst] <= counts_q[dst] + CW'(1);
              end
            end
          end else begin
            run_q <= 1'b1;
            rl_q <= lv_q;
            action_o <= ACT_STARTED;
            level_out_o <= lv_q;
            mark_out_o <= e_mark;
            reload_o <= rq_q;
          end
        end
        S_RM_RD: begin
          if (idx_q == counts_q[lv_q]) begin
            counts_q[lv_q] <= k_q;
            idx_q <= '0;
            k_q <= '0;
            if (lv_q == 2'd2) begin
              state_q <= S_IDLE;
              valid_o <= 1'b1;
              job_out_o <= 16'(id_q);
              reload_o <= 8'd0;
              action_o <= found_q ? ACT_REMOVED : ACT_NOT_FOUND;
              level_out_o <= flv_q;
              mark_out_o <= fmark_q;
            end else begin
              lv_q <= lv_q + 2'd1;
            end
          end else begin
            state_q <= S_RM_CHK;
          end
        end
        S_RM_CHK: begin
          state_q <= S_RM_RD;
          idx_q <= idx_q + CW'(1);
          if (e_id == id_q) begin
            if (!found_q) begin
              found_q <= 1'b1;
              flv_q <= lv_q;
              fmark_q <= e_mark;
            end
            if (run_q && rl_q == lv_q && idx_q == '0) begin
              run_q <= 1'b0;
              rl_q <= 2'd0;
            end
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
